FILE: rtl/rtsr_pkg.sv
// Shared types and constants for the rolling time series rank unit.
// Used by every module under rtl; depends on nothing else.
package rtsr_pkg;

   localparam int CHANNEL_W  = 4;
   localparam int CHAN_CODES = 2 ** CHANNEL_W;
   localparam int SAMPLE_W   = 32;
   localparam int WIN_LEN_W  = 7;
   localparam int COUNT_W    = 7;
   localparam int FRAC_W     = 17;
   localparam int DIV_STEPS  = 17;
   localparam int DIV_CNT_W  = 5;

   localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 7'd10;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_DONE
   } rtsr_state_type;

   typedef struct packed {
      logic                 start;
      logic [COUNT_W-1:0]   dividend;
      logic [WIN_LEN_W-1:0] divisor;
   } rtsr_div_req_type;

   typedef struct packed {
      logic              done;
      logic [FRAC_W-1:0] quotient;
   } rtsr_div_rsp_type;

endpackage

FILE: rtl/rolling_time_series_rank_unit.sv
// Rolling window rank per channel: count of the newest W samples <= the newest one.
// An accepted beat is stored in its channel ring; with a full window one comparator
// then scans one stored sample per cycle, and a 17-step serial divide runs. During warm-up
// the result follows the store directly. One beat at a time: a new beat is taken only
// once the result is loaded for output. Reset is synchronous; afterwards a clearing
// pass zeroes per-channel fill counts and ring positions; no beat is taken meanwhile.
module rolling_time_series_rank_unit
   import rtsr_pkg::*;
#(
   parameter int MAX_WINDOW = 64,
   parameter int CHANNELS   = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [WIN_LEN_W-1:0] csr_wr_data,  // window_length
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [39:0]          req_tdata,    // channel[3:0], sample[35:4], zero pad
   input  logic                 req_tuser,    // first_of_series
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,    // channel_out[3:0], rank_count[10:4],
                                              // rank_fraction[27:11], zero pad
   output logic                 rsp_tuser     // rank_valid
);

   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int POS_W    = $clog2(MAX_WINDOW);
   localparam int FILL_W   = $clog2(MAX_WINDOW + 1);
   localparam int DEPTH    = CHANNELS * MAX_WINDOW;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CMP_W    = (FILL_W > WIN_LEN_W) ? FILL_W : WIN_LEN_W;
   localparam logic [WIN_LEN_W-1:0] MAX_CLAMP =
      (MAX_WINDOW > 127) ? 7'd127 : WIN_LEN_W'(MAX_WINDOW);

   rtsr_state_type state_ff, state_in;

   logic [WIN_LEN_W-1:0] win_len_ff;
   logic [WIN_LEN_W-1:0] win_eff;

   logic [CH_W-1:0] ch_map [CHAN_CODES];
   logic [CH_W-1:0] req_ch_idx;

   logic [CH_W-1:0]      clr_idx_ff, clr_idx_in;
   logic [CHANNEL_W-1:0] chan_field_ff;
   logic [SAMPLE_W-1:0]  sample_ff;
   logic                 first_ff;
   logic [CH_W-1:0]      ch_idx_ff;
   logic [ADDR_W-1:0]    base_ff;

   logic [FILL_W-1:0] fill_mem [CHANNELS];
   logic [POS_W-1:0]  pos_mem [CHANNELS];
   logic [FILL_W-1:0] fill_rd_ff;
   logic [POS_W-1:0]  pos_rd_ff;
   logic              st_we;
   logic [CH_W-1:0]   st_waddr;
   logic [FILL_W-1:0] st_wfill;
   logic [POS_W-1:0]  st_wpos;

   logic [FILL_W-1:0] fill0;
   logic [POS_W-1:0]  pos0;
   logic [FILL_W-1:0] fill_new;

   logic [WIN_LEN_W-1:0] w_ff, w_in;
   logic                 ok_ff, ok_in;
   logic [POS_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [WIN_LEN_W-1:0] issue_ff, issue_in;
   logic                 pend_ff, pend_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [FRAC_W-1:0]    frac_ff, frac_in;
   logic                 hit;
   logic                 issue;

   logic                 win_we;
   logic [ADDR_W-1:0]    win_waddr;
   logic [ADDR_W-1:0]    win_raddr;
   logic [SAMPLE_W-1:0]  win_rdata;

   rtsr_div_req_type div_req;
   rtsr_div_rsp_type div_rsp;

   logic                 out_load;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHANNEL_W-1:0] rsp_chan_ff;
   logic                 rsp_ok_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic [FRAC_W-1:0]    rsp_frac_ff;

   // Channel codes beyond CHANNELS fold back onto the stored channels.
   for (genvar g = 0; g < CHAN_CODES; g++) begin : g_ch_map
      assign ch_map[g] = CH_W'(g % CHANNELS);
   end
   assign req_ch_idx = ch_map[req_tdata[CHANNEL_W-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff <= WIN_LEN_RESET;
      end else if (csr_wr_en) begin
         win_len_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (win_len_ff == '0) begin
         win_eff = WIN_LEN_W'(1);
      end else if (win_len_ff > MAX_CLAMP) begin
         win_eff = MAX_CLAMP;
      end else begin
         win_eff = win_len_ff;
      end
   end

   // Per-channel fill count and ring position.
   always_ff @(posedge clock) begin
      if (st_we) begin
         fill_mem[st_waddr] <= st_wfill;
         pos_mem[st_waddr]  <= st_wpos;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         fill_rd_ff <= fill_mem[req_ch_idx];
         pos_rd_ff  <= pos_mem[req_ch_idx];
      end
   end

   assign fill0    = first_ff ? '0 : fill_rd_ff;
   assign pos0     = first_ff ? '0 : pos_rd_ff;
   assign fill_new = (fill0 < FILL_W'(MAX_WINDOW)) ? fill0 + 1'b1 : fill0;

   assign issue = (state_ff == ST_SCAN) && (issue_ff < w_ff);
   assign hit   = pend_ff && ($signed(win_rdata) <= $signed(sample_ff));

   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      st_we      = 1'b0;
      st_waddr   = ch_idx_ff;
      st_wfill   = fill_new;
      st_wpos    = (pos0 == POS_W'(MAX_WINDOW - 1)) ? '0 : pos0 + 1'b1;
      win_we     = 1'b0;
      win_waddr  = base_ff + ADDR_W'(pos0);
      win_raddr  = base_ff + ADDR_W'(rd_ptr_ff);
      w_in       = w_ff;
      ok_in      = ok_ff;
      rd_ptr_in  = rd_ptr_ff;
      issue_in   = issue_ff;
      pend_in    = 1'b0;
      count_in   = count_ff;
      frac_in    = frac_ff;
      req_tready = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = count_ff;
      div_req.divisor  = w_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            st_we      = 1'b1;
            st_waddr   = clr_idx_ff;
            st_wfill   = '0;
            st_wpos    = '0;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == CH_W'(CHANNELS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            st_we     = 1'b1;
            win_we    = 1'b1;
            w_in      = win_eff;
            ok_in     = (CMP_W'(fill_new) >= CMP_W'(win_eff));
            rd_ptr_in = pos0;
            issue_in  = '0;
            count_in  = '0;
            frac_in   = '0;
            state_in  = ok_in ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            // Reads are issued newest first; each compare happens in the cycle after its read.
            pend_in  = issue;
            count_in = count_ff + COUNT_W'(hit);
            if (issue) begin
               issue_in  = issue_ff + 1'b1;
               rd_ptr_in = (rd_ptr_ff == '0) ? POS_W'(MAX_WINDOW - 1) : rd_ptr_ff - 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               frac_in  = div_rsp.quotient;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         chan_field_ff <= req_tdata[CHANNEL_W-1:0];
         sample_ff     <= req_tdata[CHANNEL_W +: SAMPLE_W];
         first_ff      <= req_tuser;
         ch_idx_ff     <= req_ch_idx;
         base_ff       <= ADDR_W'(req_ch_idx * MAX_WINDOW);
      end
      w_ff      <= w_in;
      ok_ff     <= ok_in;
      rd_ptr_ff <= rd_ptr_in;
      issue_ff  <= issue_in;
      count_ff  <= count_in;
      frac_ff   <= frac_in;
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_chan_ff  <= chan_field_ff;
         rsp_ok_ff    <= ok_ff;
         rsp_count_ff <= count_ff;
         rsp_frac_ff  <= frac_ff;
      end
   end

   rtsr_window_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_window_mem (
      .clock   (clock),
      .wr_en   (win_we),
      .wr_addr (win_waddr),
      .wr_data (sample_ff),
      .rd_en   (issue),
      .rd_addr (win_raddr),
      .rd_data (win_rdata)
   );

   rtsr_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {4'b0000, rsp_frac_ff, rsp_count_ff, rsp_chan_ff};

   property p_count_within_window;
      @(posedge clock) disable iff (reset)
         (state_ff == ST_DIV_START) |-> (count_ff <= w_ff);
   endproperty
   assert property (p_count_within_window)
      else $error("rank count exceeds the window length");

   property p_valid_rank_counts_newest;
      @(posedge clock) disable iff (reset)
         (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[10:4] != '0);
   endproperty
   assert property (p_valid_rank_counts_newest)
      else $error("full-window result does not count the newest sample");

   property p_warmup_result_zero;
      @(posedge clock) disable iff (reset)
         (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[27:4] == '0);
   endproperty
   assert property (p_warmup_result_zero)
      else $error("warm-up result carries a nonzero rank");

   property p_div_done_only_when_waiting;
      @(posedge clock) disable iff (reset)
         div_rsp.done |-> (state_ff == ST_DIV_WAIT);
   endproperty
   assert property (p_div_done_only_when_waiting)
      else $error("divider finished outside the wait state");

endmodule

FILE: rtl/rtsr_window_mem.sv
// Sample ring storage for all channels: one write port, one registered read port.
// Depends on rtsr_pkg for the sample width.
module rtsr_window_mem
   import rtsr_pkg::*;
#(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [SAMPLE_W-1:0] wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output logic [SAMPLE_W-1:0] rd_data
);

   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rtsr_divider.sv
// Restoring divider, one quotient bit per cycle: floor(dividend * 2^16 / divisor).
// Assumes dividend <= divisor; depends on rtsr_pkg for widths and the request types.
module rtsr_divider
   import rtsr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  rtsr_div_req_type div_req,
   output rtsr_div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic [WIN_LEN_W-1:0] rem_ff, rem_in;
   logic [WIN_LEN_W-1:0] dvs_ff, dvs_in;
   logic [FRAC_W-1:0]    quo_ff, quo_in;
   logic [WIN_LEN_W:0]   trial;
   logic [WIN_LEN_W:0]   diff;
   logic                 qbit;

   always_comb begin
      // The first step takes the integer bit without shifting the remainder.
      trial   = (step_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      diff    = trial - {1'b0, dvs_ff};
      qbit    = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = qbit ? diff[WIN_LEN_W-1:0] : trial[WIN_LEN_W-1:0];
         quo_in  = {quo_ff[FRAC_W-2:0], qbit};
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   property p_no_restart_while_busy;
      @(posedge clock) disable iff (reset) busy_ff |-> !div_req.start;
   endproperty
   assert property (p_no_restart_while_busy)
      else $error("divider restarted while busy");

   property p_rem_below_divisor;
      @(posedge clock) disable iff (reset) (busy_ff && step_ff != '0) |-> (rem_ff < dvs_ff);
   endproperty
   assert property (p_rem_below_divisor)
      else $error("divider remainder not below divisor");

   property p_done_follows_busy;
      @(posedge clock) disable iff (reset) done_ff |-> $past(busy_ff);
   endproperty
   assert property (p_done_follows_busy)
      else $error("divider done without a running division");

endmodule

FILE: verif/rolling_time_series_rank_unit_tb.sv
// Self-checking testbench for rolling_time_series_rank_unit: a directed warm-up, then random
// phases over several window lengths, with bursty input and a stalling result port.
// Depends on rtl/rtsr_pkg.sv and rtl/rolling_time_series_rank_unit.sv.
module rolling_time_series_rank_unit_tb;
   import rtsr_pkg::*;

   localparam int MAX_WIN  = 64;
   localparam int CHAN_NUM = 16;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [SAMPLE_W-1:0]  sample;
      logic                 first;
   } sample_beat_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic                 valid;
      logic [COUNT_W-1:0]   count;
      logic [FRAC_W-1:0]    fraction;
   } rank_result_type;

   typedef enum int {RX_FREE, RX_COIN, RX_SPARSE} rx_mode_type;
   typedef enum int {SMP_TIES, SMP_WIDE, SMP_EDGE} smp_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [WIN_LEN_W-1:0] csr_wr_data = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [39:0]          req_tdata = '0;   // channel[3:0], sample[35:4], zero pad
   logic                 req_tuser = 1'b0; // first_of_series
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;        // channel_out[3:0], rank_count[10:4],
                                           // rank_fraction[27:11], zero pad
   logic                 rsp_tuser;        // rank_valid

   rolling_time_series_rank_unit #(
      .MAX_WINDOW(MAX_WIN),
      .CHANNELS  (CHAN_NUM)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the per-channel history.
   logic signed [SAMPLE_W-1:0] ring_mem [CHAN_NUM][MAX_WIN];
   int                         held_count [CHAN_NUM];
   int                         ring_pos [CHAN_NUM];
   logic [WIN_LEN_W-1:0]       win_setting = WIN_LEN_RESET;

   sample_beat_type sample_backlog [$];
   rank_result_type pending_ranks [$];
   int              mismatch_count = 0;

   int phase_win [8]  = '{0, 64, 127, 2, 65, 5, 1, 10};
   int phase_len [10] = '{60, 150, 80, 80, 60, 80, 50, 80, 80, 80};

   initial begin
      for (int c = 0; c < CHAN_NUM; c++) begin
         held_count[c] = 0;
         ring_pos[c]   = 0;
      end
   end

   function automatic int eff_window(logic [WIN_LEN_W-1:0] setting);
      if (setting == 0)
         return 1;
      if (setting > MAX_WIN)
         return MAX_WIN;
      return int'(setting);
   endfunction

   // Stores the sample in its channel's ring and ranks it against the newest W samples.
   function automatic rank_result_type rank_of_newest(sample_beat_type b);
      int              w;
      int              ch;
      int              pos;
      int              slot;
      int              cnt;
      rank_result_type r;
      w  = eff_window(win_setting);
      ch = b.channel % CHAN_NUM;
      if (b.first) begin
         held_count[ch] = 0;
         ring_pos[ch]   = 0;
      end
      pos = ring_pos[ch];
      ring_mem[ch][pos] = b.sample;
      ring_pos[ch] = (pos + 1) % MAX_WIN;
      if (held_count[ch] < MAX_WIN)
         held_count[ch]++;
      r = '0;
      r.channel = b.channel;
      if (held_count[ch] >= w) begin
         cnt = 0;
         for (int k = 0; k < w; k++) begin
            slot = (pos + MAX_WIN - k) % MAX_WIN;
            if (ring_mem[ch][slot] <= $signed(b.sample))
               cnt++;
         end
         r.valid    = 1'b1;
         r.count    = COUNT_W'(cnt);
         r.fraction = FRAC_W'((cnt << 16) / w);
      end
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Sender: bursts of random length separated by random gaps.
   sample_beat_type drv_beat;
   int              burst_left = 1;
   int              gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            pending_ranks.push_back(rank_of_newest(drv_beat));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (sample_backlog.size() != 0) begin
               drv_beat = sample_backlog.pop_front();
               req_tdata  <= {4'b0, drv_beat.sample, drv_beat.channel};
               req_tuser  <= drv_beat.first;
               req_tvalid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: ready pattern switches between free-running, coin-flip and sparse stretches.
   rx_mode_type     rx_mode = RX_FREE;
   int              rx_span = 0;
   int              rx_tick = 0;
   rank_result_type got_rank;
   rank_result_type want_rank;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_rank.channel  = rsp_tdata[3:0];
            got_rank.count    = rsp_tdata[10:4];
            got_rank.fraction = rsp_tdata[27:11];
            got_rank.valid    = rsp_tuser;
            if (pending_ranks.size() == 0) begin
               $error("result beat for channel %0d arrived with no rank pending",
                      got_rank.channel);
               mismatch_count++;
            end else begin
               want_rank = pending_ranks.pop_front();
               check_field("channel_out", 32'(want_rank.channel), 32'(got_rank.channel));
               check_field("rank_valid", 32'(want_rank.valid), 32'(got_rank.valid));
               check_field("rank_count", 32'(want_rank.count), 32'(got_rank.count));
               check_field("rank_fraction", 32'(want_rank.fraction),
                           32'(got_rank.fraction));
            end
         end
         if (rx_span == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            rx_span = $urandom_range(20, 200);
         end else begin
            rx_span--;
         end
         rx_tick++;
         case (rx_mode)
            RX_FREE: begin
               rsp_tready <= 1'b1;
            end
            RX_COIN: begin
               rsp_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
               rsp_tready <= (rx_tick % 5 == 0);
            end
         endcase
      end
   end

   task automatic push_beat(int ch, logic [SAMPLE_W-1:0] value, bit first);
      sample_beat_type b;
      b.channel = CHANNEL_W'(ch);
      b.sample  = value;
      b.first   = first;
      sample_backlog.push_back(b);
   endtask

   task automatic wait_idle();
      while (sample_backlog.size() != 0 || req_tvalid || pending_ranks.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_window(logic [WIN_LEN_W-1:0] value);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      win_setting = value;
   endtask

   // Mostly a few channels per phase so that long windows fill up; ties are common.
   task automatic push_random_beat(int base, int chans, int w_eff);
      int                  ch;
      logic [SAMPLE_W-1:0] value;
      smp_mode_type        mode;
      if ($urandom_range(0, 9) == 0)
         ch = $urandom_range(0, CHAN_NUM - 1);
      else
         ch = (base + $urandom_range(0, chans - 1)) % CHAN_NUM;
      mode = smp_mode_type'($urandom_range(0, 2));
      case (mode)
         SMP_TIES: begin
            value = $urandom_range(0, 7) - 4;
         end
         SMP_WIDE: begin
            value = $urandom;
         end
         default: begin
            case ($urandom_range(0, 3))
               0: value = 32'h8000_0000;
               1: value = 32'h7fff_ffff;
               2: value = 32'h0000_0000;
               default: value = 32'hffff_ffff;
            endcase
         end
      endcase
      push_beat(ch, value, $urandom_range(0, 3 * w_eff + 10) == 0);
   endtask

   initial begin : stimulus
      int w;
      int w_eff;
      int chans;
      int base;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset window of ten on the top channel: extremes, ties, a full-window rank.
      push_beat(15, 32'h8000_0000, 1'b1);
      push_beat(15, 32'h7fff_ffff, 1'b0);
      push_beat(15, 32'h0000_0000, 1'b0);
      push_beat(15, 32'hffff_ffff, 1'b0);
      push_beat(15, 32'h0000_0001, 1'b0);
      push_beat(15, 32'h8000_0000, 1'b0);
      push_beat(15, 32'h7fff_ffff, 1'b0);
      push_beat(15, 32'hffff_ffff, 1'b0);
      push_beat(15, 32'h0000_0000, 1'b0);
      push_beat(15, 32'h0000_0000, 1'b0);
      push_beat(15, 32'h8000_0000, 1'b0);
      push_beat(15, 32'h7fff_ffff, 1'b0);
      push_beat(0, 32'h0000_0005, 1'b1);
      // Window of one is valid at once, even right after a series restart.
      write_window(7'd1);
      push_beat(7, 32'h7fff_ffff, 1'b0);
      push_beat(15, 32'h8000_0000, 1'b1);
      // Oversized window saturates; the short history on channel 15 is not enough.
      write_window(7'd127);
      push_beat(15, 32'h1234_5678, 1'b0);
      push_beat(0, 32'hffff_fffe, 1'b0);

      for (int p = 0; p < 10; p++) begin
         w = (p < 8) ? phase_win[p] : $urandom_range(1, MAX_WIN);
         write_window(w[WIN_LEN_W-1:0]);
         w_eff = eff_window(w[WIN_LEN_W-1:0]);
         chans = (w_eff >= 32) ? 2 : (w_eff >= 8) ? 4 : CHAN_NUM;
         base  = $urandom_range(0, CHAN_NUM - 1);
         repeat (phase_len[p])
            push_random_beat(base, chans, w_eff);
      end

      wait_idle();
      repeat (100) @(negedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: rolling_time_series_rank_unit.f
rtl/rtsr_pkg.sv
rtl/rtsr_window_mem.sv
rtl/rtsr_divider.sv
rtl/rolling_time_series_rank_unit.sv
verif/rolling_time_series_rank_unit_tb.sv
